FILE: sv/ssv_pkg.sv
package ssv_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;
  localparam int CFG_BITS    = 16;

  // wide enough for a difference of two samples and for previous value +/- max step
  localparam int WORK_BITS     = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS + 2 : CFG_BITS + 2;
  localparam int CNT_CMP_BITS  = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
  localparam int CFG_DATA_BITS = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;
  localparam int CFG_IDX_BITS  = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic        [CFG_BITS-1:0]    cfg_word_t;
  typedef logic        [COUNT_BITS-1:0]  count_t;
  typedef logic signed [WORK_BITS-1:0]   work_t;
  typedef logic        [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam count_t  COUNT_MAX  = {COUNT_BITS{1'b1}};

  // register indexes of the configuration port
  localparam cfg_idx_t CFG_RANGE_LOW   = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_RANGE_HIGH  = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_MAX_STEP    = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_STILL_TOL   = cfg_idx_t'(3);
  localparam cfg_idx_t CFG_STILL_LIMIT = cfg_idx_t'(4);

  typedef struct packed {
    sample_t   range_low;
    sample_t   range_high;
    cfg_word_t max_step;
    cfg_word_t still_tolerance;
    cfg_word_t still_limit;
  } cfg_t;

  typedef struct packed {
    sample_t previous_value;
    count_t  still_count;
    logic    seeded;
  } state_t;

  typedef struct packed {
    sample_t raw_echo;
    sample_t clean_value;
    logic    is_valid;
    logic    fault_range;
    logic    fault_rate;
    logic    fault_stuck;
  } result_t;

endpackage

FILE: sv/ssv_if.sv
interface ssv_sample_if import ssv_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface ssv_result_if import ssv_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t raw_echo;
  sample_t clean_value;
  logic    is_valid;
  logic    fault_range;
  logic    fault_rate;
  logic    fault_stuck;

  modport source (output valid, output raw_echo, output clean_value, output is_valid,
                  output fault_range, output fault_rate, output fault_stuck, input ready);
  modport sink   (input valid, input raw_echo, input clean_value, input is_valid,
                  input fault_range, input fault_rate, input fault_stuck, output ready);
endinterface

interface ssv_cfg_if import ssv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  cfg_idx_t                 index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/ssv_check.sv
module ssv_check import ssv_pkg::*; (
  input  sample_t raw_i,
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  output result_t result_o,
  output state_t  state_o
);

  logic    below, above, rate_hit, still;
  sample_t clamped, limited, clean;
  work_t   prev_w, clamp_w, step_w, tol_w, clean_w;
  work_t   diff_in, abs_in, diff_out, abs_out, lim_w;
  count_t  count_d;
  logic    stuck;

  always_comb begin
    below   = raw_i < cfg_i.range_low;
    above   = raw_i > cfg_i.range_high;
    // an inverted range resolves to range_low first
    clamped = below ? cfg_i.range_low : (above ? cfg_i.range_high : raw_i);

    prev_w  = WORK_BITS'(state_i.previous_value);
    clamp_w = WORK_BITS'(clamped);
    step_w  = $signed(WORK_BITS'(cfg_i.max_step));
    tol_w   = $signed(WORK_BITS'(cfg_i.still_tolerance));

    diff_in = clamp_w - prev_w;
    abs_in  = diff_in[WORK_BITS-1] ? -diff_in : diff_in;
    rate_hit = state_i.seeded && (cfg_i.max_step != '0) && (abs_in > step_w);

    lim_w = (clamp_w > prev_w) ? prev_w + step_w : prev_w - step_w;
    if (lim_w > WORK_BITS'(SAMPLE_MAX)) begin
      limited = SAMPLE_MAX;
    end else if (lim_w < WORK_BITS'(SAMPLE_MIN)) begin
      limited = SAMPLE_MIN;
    end else begin
      limited = lim_w[SAMPLE_BITS-1:0];
    end
    clean = rate_hit ? limited : clamped;

    clean_w  = WORK_BITS'(clean);
    diff_out = clean_w - prev_w;
    abs_out  = diff_out[WORK_BITS-1] ? -diff_out : diff_out;
    still    = abs_out < tol_w;

    if (!state_i.seeded) begin
      count_d = '0;
    end else if (cfg_i.still_limit == '0) begin
      count_d = state_i.still_count;
    end else if (still) begin
      count_d = (state_i.still_count != COUNT_MAX) ? state_i.still_count + 1'b1
                                                   : state_i.still_count;
    end else begin
      count_d = '0;
    end
    stuck = state_i.seeded && (cfg_i.still_limit != '0) &&
            (CNT_CMP_BITS'(count_d) >= CNT_CMP_BITS'(cfg_i.still_limit));

    result_o.raw_echo    = raw_i;
    result_o.clean_value = clean;
    result_o.fault_range = below | above;
    result_o.fault_rate  = rate_hit;
    result_o.fault_stuck = stuck;
    result_o.is_valid    = !(below | above | stuck);

    state_o.previous_value = clean;
    state_o.still_count    = count_d;
    state_o.seeded         = 1'b1;
  end

endmodule

FILE: sv/sensor_sample_validator.sv
// Sensor sample validator.
// sample_i takes one raw signed sample per request; result_o returns one result per
// sample, in order: the raw sample echoed, the cleaned value and the valid/fault flags.
// cfg_i writes the five configuration registers by index (range low, range high,
// max step, still tolerance, still limit); it is always ready, and writes are meant
// to happen only while no sample is in flight. Unknown indexes are dropped.
// A sample accepted into the input register is checked combinationally and shown on
// result_o once the result register loads. Throughput is one sample per cycle while
// the receiver does not stall; the previous-value / still-count feedback closes
// through the clamp, subtract and compare logic alone.
// Reset sets the range to the full sample range, turns rate and stuck checks off
// and clears the seeded flag, so the first sample afterwards only seeds the last
// value. When the receiver stalls, the result register holds and the input register
// still takes one more sample; sample_i.ready then drops until result_o moves.
module sensor_sample_validator import ssv_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ssv_sample_if.sink   sample_i,
  ssv_result_if.source result_o,
  ssv_cfg_if.sink      cfg_i
);

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  logic    in_valid_q, out_valid_q;
  sample_t in_raw_q;
  result_t out_q, result_d;
  logic    out_free, in_adv;

  assign out_free = !out_valid_q || result_o.ready;
  assign in_adv   = in_valid_q && out_free;

  assign sample_i.ready = !in_valid_q || out_free;
  assign cfg_i.ready    = 1'b1;

  ssv_check u_check (
    .raw_i    (in_raw_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .result_o (result_d),
    .state_o  (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_low       <= SAMPLE_MIN;
      cfg_q.range_high      <= SAMPLE_MAX;
      cfg_q.max_step        <= '0;
      cfg_q.still_tolerance <= '0;
      cfg_q.still_limit     <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_RANGE_LOW:   cfg_q.range_low       <= cfg_i.data[SAMPLE_BITS-1:0];
        CFG_RANGE_HIGH:  cfg_q.range_high      <= cfg_i.data[SAMPLE_BITS-1:0];
        CFG_MAX_STEP:    cfg_q.max_step        <= cfg_i.data[CFG_BITS-1:0];
        CFG_STILL_TOL:   cfg_q.still_tolerance <= cfg_i.data[CFG_BITS-1:0];
        CFG_STILL_LIMIT: cfg_q.still_limit     <= cfg_i.data[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (sample_i.ready) begin
        in_valid_q <= sample_i.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (in_adv) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      in_raw_q <= sample_i.raw_sample;
    end
    if (in_adv) begin
      out_q <= result_d;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.raw_echo    = out_q.raw_echo;
  assign result_o.clean_value = out_q.clean_value;
  assign result_o.is_valid    = out_q.is_valid;
  assign result_o.fault_range = out_q.fault_range;
  assign result_o.fault_rate  = out_q.fault_rate;
  assign result_o.fault_stuck = out_q.fault_stuck;

  a_seed_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_adv |=> state_q.seeded)
    else $error("seeded flag not set after a sample");

  a_count_clear_unseeded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.seeded |-> state_q.still_count == '0)
    else $error("still count non-zero before seeding");

  a_input_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(in_raw_q))
    else $error("input stage lost a sample under stall");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_adv |=> $stable(state_q))
    else $error("state changed without a sample moving on");

  a_fault_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_adv && (result_d.fault_range || result_d.fault_stuck) |=> !out_q.is_valid)
    else $error("fault reported as valid");

endmodule
